// File: sv/cmc_pkg.sv
package cmc_pkg;

   localparam int COEF_BITS_DEF  = 12;
   localparam int PIXEL_BITS_DEF = 8;
   localparam int DEN_BITS       = 12;
   localparam int OUT_BITS       = 8;
   localparam int QUO_BITS       = 8;
   localparam int SUM_BITS       = OUT_BITS + 2;
   localparam int CSR_IDX_BITS   = 3;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      REG_ROW_ZERO = 3'd0,
      REG_ROW_ONE  = 3'd1,
      REG_ROW_TWO  = 3'd2,
      REG_DENOM    = 3'd3,
      REG_MODE     = 3'd4
   } csr_index_type;

   // Reset matrix, listed red, green, blue for each row.
   localparam int ROW0_RED = 607;
   localparam int ROW0_GRN = 174;
   localparam int ROW0_BLU = 201;
   localparam int ROW1_RED = 299;
   localparam int ROW1_GRN = 587;
   localparam int ROW1_BLU = 114;
   localparam int ROW2_RED = 0;
   localparam int ROW2_GRN = 66;
   localparam int ROW2_BLU = 1117;
   localparam int DENOM_RESET = 1000;

   typedef struct packed {
      logic [OUT_BITS-1:0] t;
      logic                clip;
   } row_res_type;

endpackage

// File: sv/cmc_matrix.sv
module cmc_matrix #(
   parameter int COEF_BITS  = cmc_pkg::COEF_BITS_DEF,
   parameter int PIXEL_BITS = cmc_pkg::PIXEL_BITS_DEF,
   localparam int ACC_W     = PIXEL_BITS + COEF_BITS + 2,
   localparam int PROD_W    = PIXEL_BITS + COEF_BITS + 1
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       in_valid,
   input  logic [PIXEL_BITS-1:0]      pix [0:2],
   input  logic [3*COEF_BITS-1:0]     rows [0:2],
   output logic                       out_valid,
   output logic signed [ACC_W-1:0]    acc [0:2]
);

   logic signed [PROD_W-1:0] prod_in [0:8];
   logic signed [PROD_W-1:0] prod_ff [0:8];
   logic signed [ACC_W-1:0]  acc_in  [0:2];
   logic signed [ACC_W-1:0]  acc_ff  [0:2];
   logic                     v1_ff, v2_ff;

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            prod_in[3*r+c] = $signed({1'b0, pix[c]})
                           * $signed(rows[r][c*COEF_BITS +: COEF_BITS]);
         end
      end
      for (int r = 0; r < 3; r++) begin
         acc_in[r] = ACC_W'(prod_ff[3*r]) + ACC_W'(prod_ff[3*r+1])
                   + ACC_W'(prod_ff[3*r+2]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
      if (en) begin
         prod_ff <= prod_in;
         acc_ff  <= acc_in;
      end
   end

   assign out_valid = v2_ff;
   assign acc       = acc_ff;

endmodule

// File: sv/cmc_rowdiv.sv
module cmc_rowdiv #(
   parameter int ACC_W = cmc_pkg::PIXEL_BITS_DEF + cmc_pkg::COEF_BITS_DEF + 2
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           en,
   input  logic                           in_valid,
   input  logic signed [ACC_W-1:0]        acc,
   input  logic [cmc_pkg::DEN_BITS-1:0]   den,
   output logic                           out_valid,
   output cmc_pkg::row_res_type           res
);

   localparam int MAG_W = ACC_W - 1;
   localparam int SHW   = cmc_pkg::DEN_BITS + cmc_pkg::QUO_BITS;
   localparam int CMP_W = (MAG_W > SHW ? MAG_W : SHW) + 1;
   localparam int NST   = cmc_pkg::QUO_BITS;

   logic                         neg_ff [0:NST];
   logic                         big_ff [0:NST];
   logic                         vld_ff [0:NST];
   logic [CMP_W-1:0]             rem_ff [0:NST];
   logic [CMP_W-1:0]             rem_in [1:NST];
   logic [cmc_pkg::QUO_BITS-1:0] q_ff   [0:NST];
   logic [cmc_pkg::QUO_BITS-1:0] q_in   [1:NST];
   logic signed [ACC_W-1:0]      neg_acc;
   logic [CMP_W-1:0]             mag0;
   logic [CMP_W-1:0]             trial;
   cmc_pkg::row_res_type         res_in, res_ff;
   logic                         res_v_ff;

   always_comb begin
      neg_acc = -acc;
      mag0 = acc[ACC_W-1] ? CMP_W'(neg_acc[MAG_W-1:0]) : CMP_W'(acc[MAG_W-1:0]);
      trial = '0;
      for (int i = 1; i <= NST; i++) begin
         trial = CMP_W'(den) << (NST - i);
         q_in[i] = q_ff[i-1];
         if (rem_ff[i-1] >= trial) begin
            rem_in[i] = rem_ff[i-1] - trial;
            q_in[i][NST-i] = 1'b1;
         end else begin
            rem_in[i] = rem_ff[i-1];
         end
      end
      // Truncation toward zero: a negative sum smaller than the divisor
      // gives zero without saturating.
      if (neg_ff[NST]) begin
         res_in.t    = '0;
         res_in.clip = big_ff[NST] || (q_ff[NST] != '0);
      end else if (big_ff[NST]) begin
         res_in.t    = '1;
         res_in.clip = 1'b1;
      end else begin
         res_in.t    = q_ff[NST];
         res_in.clip = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= NST; i++) vld_ff[i] <= 1'b0;
         res_v_ff <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= in_valid;
         for (int i = 1; i <= NST; i++) vld_ff[i] <= vld_ff[i-1];
         res_v_ff <= vld_ff[NST];
      end
      if (en) begin
         neg_ff[0] <= acc[ACC_W-1];
         big_ff[0] <= mag0 >= (CMP_W'(den) << NST);
         rem_ff[0] <= mag0;
         q_ff[0]   <= '0;
         for (int i = 1; i <= NST; i++) begin
            neg_ff[i] <= neg_ff[i-1];
            big_ff[i] <= big_ff[i-1];
            rem_ff[i] <= rem_in[i];
            q_ff[i]   <= q_in[i];
         end
         res_ff <= res_in;
      end
   end

   assign out_valid = res_v_ff;
   assign res       = res_ff;

endmodule

// File: sv/cmc_chroma.sv
module cmc_chroma (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           en,
   input  logic                           in_valid,
   input  logic                           mode,
   input  cmc_pkg::row_res_type           rin [0:2],
   output logic                           out_valid,
   output logic [cmc_pkg::OUT_BITS-1:0]   coord [0:2],
   output logic                           clip
);

   localparam int OB    = cmc_pkg::OUT_BITS;
   localparam int NST   = OB + 1;
   localparam int CW    = cmc_pkg::SUM_BITS + OB + 1;

   logic [cmc_pkg::SUM_BITS-1:0] sum0;
   logic [cmc_pkg::SUM_BITS-1:0] sum_ff  [0:NST];
   logic [CW-1:0]                rem_ff  [0:NST][0:1];
   logic [CW-1:0]                rem_in  [1:NST][0:1];
   logic [NST-1:0]               q_ff    [0:NST][0:1];
   logic [NST-1:0]               q_in    [1:NST][0:1];
   logic [OB-1:0]                t_ff    [0:NST][0:2];
   logic                         clip_ff [0:NST];
   logic                         mode_ff [0:NST];
   logic                         vld_ff  [0:NST];
   logic [CW-1:0]                trial;
   logic [OB-1:0]                out_in  [0:2];
   logic                         clip_in;
   logic [OB-1:0]                out_ff  [0:2];
   logic                         clip_o_ff, out_v_ff;

   always_comb begin
      sum0 = cmc_pkg::SUM_BITS'(rin[0].t) + cmc_pkg::SUM_BITS'(rin[1].t)
           + cmc_pkg::SUM_BITS'(rin[2].t);
      trial = '0;
      for (int i = 1; i <= NST; i++) begin
         trial = CW'(sum_ff[i-1]) << (NST - i);
         for (int k = 0; k < 2; k++) begin
            q_in[i][k] = q_ff[i-1][k];
            if (rem_ff[i-1][k] >= trial) begin
               rem_in[i][k] = rem_ff[i-1][k] - trial;
               q_in[i][k][NST-i] = 1'b1;
            end else begin
               rem_in[i][k] = rem_ff[i-1][k];
            end
         end
      end
      clip_in   = clip_ff[NST];
      out_in[2] = t_ff[NST][2];
      for (int k = 0; k < 2; k++) begin
         if (!mode_ff[NST]) begin
            out_in[k] = t_ff[NST][k];
         end else if (sum_ff[NST] == '0) begin
            out_in[k] = '0;
         end else if (q_ff[NST][k][OB]) begin
            // Only reached when the other two values are zero.
            out_in[k] = '1;
            clip_in   = 1'b1;
         end else begin
            out_in[k] = q_ff[NST][k][OB-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= NST; i++) vld_ff[i] <= 1'b0;
         out_v_ff <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= in_valid;
         for (int i = 1; i <= NST; i++) vld_ff[i] <= vld_ff[i-1];
         out_v_ff <= vld_ff[NST];
      end
      if (en) begin
         sum_ff[0]  <= sum0;
         clip_ff[0] <= rin[0].clip | rin[1].clip | rin[2].clip;
         mode_ff[0] <= mode;
         for (int k = 0; k < 3; k++) t_ff[0][k] <= rin[k].t;
         for (int k = 0; k < 2; k++) begin
            rem_ff[0][k] <= CW'({rin[k].t, {OB{1'b0}}});
            q_ff[0][k]   <= '0;
         end
         for (int i = 1; i <= NST; i++) begin
            sum_ff[i]  <= sum_ff[i-1];
            clip_ff[i] <= clip_ff[i-1];
            mode_ff[i] <= mode_ff[i-1];
            t_ff[i]    <= t_ff[i-1];
            rem_ff[i]  <= rem_in[i];
            q_ff[i]    <= q_in[i];
         end
         out_ff    <= out_in;
         clip_o_ff <= clip_in;
      end
   end

   assign out_valid = out_v_ff;
   assign coord     = out_ff;
   assign clip      = clip_o_ff;

endmodule

// File: sv/color_matrix_chromaticity_top.sv
// Throughput: one item per cycle; the whole pipeline holds while a result waits.
// The rate is set by the fully pipelined multiply stage and the two restoring
// dividers, which produce one quotient bit per stage.
// Reset (synchronous, active high) empties the pipeline and loads the default
// matrix, a denominator of 1000 and tristimulus mode.
module color_matrix_chromaticity_top #(
   parameter int COEF_BITS  = cmc_pkg::COEF_BITS_DEF,
   parameter int PIXEL_BITS = cmc_pkg::PIXEL_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [PIXEL_BITS-1:0]             req_red,
   input  logic [PIXEL_BITS-1:0]             req_green,
   input  logic [PIXEL_BITS-1:0]             req_blue,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [cmc_pkg::OUT_BITS-1:0]      rsp_coord_first,
   output logic [cmc_pkg::OUT_BITS-1:0]      rsp_coord_second,
   output logic [cmc_pkg::OUT_BITS-1:0]      rsp_coord_third,
   output logic                              rsp_clipped,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [cmc_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [3*COEF_BITS-1:0]            csr_data
);

   localparam int ACC_W = PIXEL_BITS + COEF_BITS + 2;
   localparam int ROW_W = 3 * COEF_BITS;

   // Reset rows are built from the coefficient list so that they follow
   // the coefficient width: blue sits in the top field, red at the bottom.
   localparam logic [ROW_W-1:0] ROW0_RST = {COEF_BITS'(cmc_pkg::ROW0_BLU),
      COEF_BITS'(cmc_pkg::ROW0_GRN), COEF_BITS'(cmc_pkg::ROW0_RED)};
   localparam logic [ROW_W-1:0] ROW1_RST = {COEF_BITS'(cmc_pkg::ROW1_BLU),
      COEF_BITS'(cmc_pkg::ROW1_GRN), COEF_BITS'(cmc_pkg::ROW1_RED)};
   localparam logic [ROW_W-1:0] ROW2_RST = {COEF_BITS'(cmc_pkg::ROW2_BLU),
      COEF_BITS'(cmc_pkg::ROW2_GRN), COEF_BITS'(cmc_pkg::ROW2_RED)};

   logic [ROW_W-1:0]               rows_ff [0:2];
   logic [cmc_pkg::DEN_BITS-1:0]   den_ff;
   logic                           mode_ff;
   logic [cmc_pkg::DEN_BITS-1:0]   den_eff;

   logic                           adv;
   logic [PIXEL_BITS-1:0]          pix [0:2];
   logic                           mat_valid;
   logic signed [ACC_W-1:0]        acc [0:2];
   logic [2:0]                     div_valid;
   cmc_pkg::row_res_type           row_res [0:2];
   logic [cmc_pkg::OUT_BITS-1:0]   coord [0:2];

   // Configuration registers. Writes must only arrive while the pipeline is
   // empty (the block itself does not enforce it), so the stages read these directly.
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff[0] <= ROW0_RST;
         rows_ff[1] <= ROW1_RST;
         rows_ff[2] <= ROW2_RST;
         den_ff     <= cmc_pkg::DEN_BITS'(cmc_pkg::DENOM_RESET);
         mode_ff    <= 1'b0;
      end else if (csr_valid) begin
         case (cmc_pkg::csr_index_type'(csr_index))
            cmc_pkg::REG_ROW_ZERO: rows_ff[0] <= csr_data;
            cmc_pkg::REG_ROW_ONE:  rows_ff[1] <= csr_data;
            cmc_pkg::REG_ROW_TWO:  rows_ff[2] <= csr_data;
            cmc_pkg::REG_DENOM:    den_ff  <= csr_data[cmc_pkg::DEN_BITS-1:0];
            cmc_pkg::REG_MODE:     mode_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;

   // A zero denominator divides by one.
   assign den_eff = (den_ff == '0) ? cmc_pkg::DEN_BITS'(1) : den_ff;

   // Every stage moves together. The pipeline advances whenever the output
   // register is empty or its item is being taken, so a new item can enter
   // on every cycle that the result side keeps up.
   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   assign pix[0] = req_red;
   assign pix[1] = req_green;
   assign pix[2] = req_blue;

   cmc_matrix #(
      .COEF_BITS (COEF_BITS),
      .PIXEL_BITS(PIXEL_BITS)
   ) u_matrix (
      .clock    (clock),
      .reset    (reset),
      .en       (adv),
      .in_valid (req_valid),
      .pix      (pix),
      .rows     (rows_ff),
      .out_valid(mat_valid),
      .acc      (acc)
   );

   // One divider per row; all three run in lockstep.
   for (genvar r = 0; r < 3; r++) begin : g_row
      cmc_rowdiv #(
         .ACC_W(ACC_W)
      ) u_rowdiv (
         .clock    (clock),
         .reset    (reset),
         .en       (adv),
         .in_valid (mat_valid),
         .acc      (acc[r]),
         .den      (den_eff),
         .out_valid(div_valid[r]),
         .res      (row_res[r])
      );
   end

   // The chromaticity stage carries the third value and the clip flag
   // alongside its quotients and owns the output register.
   cmc_chroma u_chroma (
      .clock    (clock),
      .reset    (reset),
      .en       (adv),
      .in_valid (div_valid[0]),
      .mode     (mode_ff),
      .rin      (row_res),
      .out_valid(rsp_valid),
      .coord    (coord),
      .clip     (rsp_clipped)
   );

   assign rsp_coord_first  = coord[0];
   assign rsp_coord_second = coord[1];
   assign rsp_coord_third  = coord[2];

endmodule

// File: sv/cmc_checker.sv
module cmc_checker #(
   parameter int COEF_BITS  = cmc_pkg::COEF_BITS_DEF,
   parameter int PIXEL_BITS = cmc_pkg::PIXEL_BITS_DEF
) (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [cmc_pkg::OUT_BITS-1:0]     rsp_coord_first,
   input logic [cmc_pkg::OUT_BITS-1:0]     rsp_coord_second,
   input logic [cmc_pkg::OUT_BITS-1:0]     rsp_coord_third,
   input logic                             rsp_clipped,
   input logic                             csr_valid,
   input logic                             csr_ready
);

   // A result that waits keeps its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_coord_first)
         && $stable(rsp_coord_second) && $stable(rsp_coord_third)
         && $stable(rsp_clipped))
      else $error("result changed while stalled");

   // Reset empties the pipeline.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result present after reset");

   // With no result pending the block must take a new item.
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty output");

   // Configuration writes are never held off.
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("configuration write stalled");

endmodule

bind color_matrix_chromaticity_top cmc_checker #(
   .COEF_BITS (COEF_BITS),
   .PIXEL_BITS(PIXEL_BITS)
) u_cmc_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_coord_first (rsp_coord_first),
   .rsp_coord_second(rsp_coord_second),
   .rsp_coord_third (rsp_coord_third),
   .rsp_clipped     (rsp_clipped),
   .csr_valid       (csr_valid),
   .csr_ready       (csr_ready)
);

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps

// Self-checking bench for the color matrix / chromaticity unit. A pixel
// predictor computes the expected coordinates for every accepted item and a
// scoreboard compares each result in order against the oldest expectation.
module testbench;
   import cmc_pkg::*;

   localparam int CB = COEF_BITS_DEF;
   localparam int PB = PIXEL_BITS_DEF;
   localparam int LATENCY = 23;

   typedef struct packed {
      logic [7:0] first;
      logic [7:0] second;
      logic [7:0] third;
      logic       clip;
   } coords_type;

   // The scoreboard keeps the expected coordinates in arrival order.
   class coord_scoreboard;
      coords_type pending[$];
      int errors;

      function new();
         errors = 0;
      endfunction

      function void note_pixel(coords_type c);
         pending.push_back(c);
      endfunction

      function void check_result(coords_type got);
         coords_type want;
         if (pending.size() == 0) begin
            $error("unexpected result %h", got);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (want.first !== got.first) begin
            $error("coord_first expected %0d got %0d", want.first, got.first);
            errors++;
         end
         if (want.second !== got.second) begin
            $error("coord_second expected %0d got %0d", want.second, got.second);
            errors++;
         end
         if (want.third !== got.third) begin
            $error("coord_third expected %0d got %0d", want.third, got.third);
            errors++;
         end
         if (want.clip !== got.clip) begin
            $error("clipped expected %0d got %0d", want.clip, got.clip);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic [PB-1:0] req_red = 0, req_green = 0, req_blue = 0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic [7:0] rsp_coord_first, rsp_coord_second, rsp_coord_third;
   logic rsp_clipped;
   logic csr_valid = 0;
   logic csr_ready;
   csr_index_type csr_index = REG_ROW_ZERO;
   logic [3*CB-1:0] csr_data = '0;

   // Shadow copy of the configuration registers.
   logic [3*CB-1:0] mat_row[3];
   logic [11:0] denom;
   logic chroma;

   coord_scoreboard board = new();

   // Stall controls: percentages of idle cycles for each side, plus a long
   // hold-off on the result side to fill the pipeline.
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   bit hold_off = 0;

   always #5 clock = ~clock;

   color_matrix_chromaticity_top i_dut (.*);

   function automatic logic [7:0] clamp8(longint v, ref logic clip);
      if (v < 0) begin
         clip = 1;
         return 8'd0;
      end
      if (v > 255) begin
         clip = 1;
         return 8'd255;
      end
      return v[7:0];
   endfunction

   // Matrix multiply, truncating divide, saturation and the optional
   // chromaticity normalization, all in 64-bit signed arithmetic.
   function automatic coords_type predict_coords(logic [PB-1:0] r, logic [PB-1:0] g,
                                                 logic [PB-1:0] b);
      longint pix[3];
      longint acc, div, sum;
      logic signed [CB-1:0] cf;
      logic [7:0] t[3];
      logic clip;
      coords_type res;
      pix[0] = r;
      pix[1] = g;
      pix[2] = b;
      clip = 0;
      div = (denom == 0) ? 1 : denom;
      for (int row = 0; row < 3; row++) begin
         acc = 0;
         for (int col = 0; col < 3; col++) begin
            cf = mat_row[row][col*CB +: CB];
            acc += pix[col] * longint'(cf);
         end
         t[row] = clamp8(acc / div, clip);
      end
      if (chroma) begin
         sum = longint'(t[0]) + t[1] + t[2];
         if (sum == 0) begin
            t[0] = 0;
            t[1] = 0;
         end else begin
            t[0] = clamp8((longint'(t[0]) << 8) / sum, clip);
            t[1] = clamp8((longint'(t[1]) << 8) / sum, clip);
         end
      end
      res.first = t[0];
      res.second = t[1];
      res.third = t[2];
      res.clip = clip;
      return res;
   endfunction

   // Write one register through the CSR channel and mirror it locally.
   task automatic write_reg(csr_index_type idx, logic [3*CB-1:0] val);
      @(negedge clock);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_ROW_ZERO: mat_row[0] = val;
         REG_ROW_ONE:  mat_row[1] = val;
         REG_ROW_TWO:  mat_row[2] = val;
         REG_DENOM:    denom = val[11:0];
         REG_MODE:     chroma = val[0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 0;
   endtask

   // Offer one pixel, optionally after random idle cycles, and wait for it
   // to be accepted. Valid is kept high between back-to-back items.
   task automatic send_pixel(logic [PB-1:0] r, logic [PB-1:0] g, logic [PB-1:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      req_red <= r;
      req_green <= g;
      req_blue <= b;
      do @(posedge clock); while (!req_ready);
      board.note_pixel(predict_coords(r, g, b));
      @(negedge clock);
   endtask

   task automatic stop_sending();
      req_valid <= 0;
   endtask

   // Wait until every expected result has come back, then let the pipeline
   // drain for its full latency before touching the registers.
   task automatic wait_idle();
      stop_sending();
      while (board.pending.size() != 0) @(negedge clock);
      repeat (LATENCY + 4) @(negedge clock);
   endtask

   function automatic logic [3*CB-1:0] rand_row();
      return {12'($urandom_range(4095)), 12'($urandom_range(4095)),
              12'($urandom_range(4095))};
   endfunction

   // A pixel drawn mostly from the full range with extremes mixed in.
   task automatic send_random_pixel();
      logic [PB-1:0] c[3];
      for (int k = 0; k < 3; k++) begin
         case ($urandom_range(5))
            0: c[k] = 0;
            1: c[k] = {PB{1'b1}};
            default: c[k] = $urandom_range(255);
         endcase
      end
      send_pixel(c[0], c[1], c[2]);
   endtask

   // Result side: sample at the rising edge, change ready at the falling edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         board.check_result({rsp_coord_first, rsp_coord_second, rsp_coord_third,
                             rsp_clipped});
   end

   always @(negedge clock) begin
      if (hold_off)
         rsp_ready <= 0;
      else
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   initial begin
      #5ms;
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      mat_row[0] = {12'(ROW0_BLU), 12'(ROW0_GRN), 12'(ROW0_RED)};
      mat_row[1] = {12'(ROW1_BLU), 12'(ROW1_GRN), 12'(ROW1_RED)};
      mat_row[2] = {12'(ROW2_BLU), 12'(ROW2_GRN), 12'(ROW2_RED)};
      denom = 12'(DENOM_RESET);
      chroma = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // Directed part with the reset matrix: extremes of every field.
      send_pixel(0, 0, 0);
      send_pixel(255, 255, 255);
      send_pixel(255, 0, 0);
      send_pixel(0, 255, 0);
      send_pixel(0, 0, 255);
      send_pixel(8'haa, 8'h55, 8'haa);
      send_pixel(8'h55, 8'haa, 8'h55);
      wait_idle();

      // Chromaticity mode, including a zero sum and a lone nonzero T that
      // gives a quotient of 256.
      write_reg(REG_MODE, 1);
      send_pixel(0, 0, 0);
      send_pixel(100, 50, 20);
      send_pixel(255, 255, 255);
      wait_idle();
      write_reg(REG_ROW_ZERO, {12'd0, 12'd0, 12'd1});
      write_reg(REG_ROW_ONE, '0);
      write_reg(REG_ROW_TWO, '0);
      write_reg(REG_DENOM, 1);
      send_pixel(77, 3, 9);
      send_pixel(0, 200, 9);
      wait_idle();

      // Zero denominator, negative rows and most-negative coefficients.
      write_reg(REG_MODE, 0);
      write_reg(REG_DENOM, 0);
      write_reg(REG_ROW_ZERO, {12'h800, 12'h800, 12'h800});
      write_reg(REG_ROW_ONE, {12'h7ff, 12'h7ff, 12'h7ff});
      write_reg(REG_ROW_TWO, {12'hfff, 12'h001, 12'h000});
      send_pixel(0, 0, 0);
      send_pixel(255, 255, 255);
      send_pixel(1, 2, 0);
      wait_idle();
      write_reg(REG_DENOM, 4095);
      send_pixel(255, 255, 255);
      send_pixel(0, 0, 1);
      wait_idle();

      // Random phases: several register settings under the three stall
      // profiles in turn.
      for (int ph = 0; ph < 9; ph++) begin
         send_idle_pct = (ph < 3) ? 9 : (ph < 6) ? 88 : 0;
         recv_idle_pct = (ph < 3) ? 88 : (ph < 6) ? 9 : 0;
         write_reg(REG_ROW_ZERO, rand_row());
         write_reg(REG_ROW_ONE, rand_row());
         write_reg(REG_ROW_TWO, rand_row());
         case (ph % 3)
            0: write_reg(REG_DENOM, $urandom_range(1, 64));
            1: write_reg(REG_DENOM, $urandom_range(4095));
            default: write_reg(REG_DENOM, 1);
         endcase
         write_reg(REG_MODE, $urandom_range(1));
         if (ph == 8) begin
            // Long receiver hold-off so the pipeline fills and stalls input.
            fork
               begin
                  hold_off = 1;
                  repeat (200) @(negedge clock);
                  hold_off = 0;
               end
            join_none
         end
         repeat (47) send_random_pixel();
         wait_idle();
      end

      if (board.errors == 0 && board.pending.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// File: filelist.f
sv/cmc_pkg.sv
sv/cmc_matrix.sv
sv/cmc_rowdiv.sv
sv/cmc_chroma.sv
sv/color_matrix_chromaticity_top.sv
sv/cmc_checker.sv
tb/sv/testbench.sv
